>>> src/spil_pkg.sv
// Package for the sorted priority insert list.
// Holds field widths, request/response structs, controller command/status
// structs, the controller state type and the priority function. No dependencies.
`timescale 1ns / 1ps

package spil_pkg;

  localparam int ID_W    = 8;
  localparam int VALUE_W = 16;
  localparam int RANK_W  = 6;
  // id + value needs one bit above the wider operand plus a sign bit
  localparam int PRIO_W  = ((ID_W > VALUE_W) ? ID_W : VALUE_W) + 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LIST   = 1'b1;

  typedef struct packed {
    logic                      command;
    logic [ID_W-1:0]           new_id;
    logic signed [VALUE_W-1:0] new_value;
  } spil_req_t;

  typedef struct packed {
    logic [ID_W-1:0]           entry_id;
    logic signed [VALUE_W-1:0] entry_value;
    logic [RANK_W-1:0]         rank;
    logic                      is_listing;
    logic                      empty_res;
    logic                      rejected;
    logic                      last;
  } spil_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS,
    ST_LIST
  } spil_state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch request, run the compare against all cells
    logic emit_ins;   // shift cells, load insert answer into output register
    logic emit_list;  // rotate cells, load next listing result
  } spil_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic req_list;   // request on the input is a listing command
    logic list_done;  // the listing result being emitted now is the final one
  } spil_stat_t;

  function automatic logic signed [PRIO_W-1:0] prio_f(
    input logic [ID_W-1:0]           id,
    input logic signed [VALUE_W-1:0] val
  );
    logic signed [PRIO_W-1:0] id_x;
    logic signed [PRIO_W-1:0] val_x;
    id_x  = $signed({{(PRIO_W-ID_W){1'b0}}, id});
    val_x = $signed({{(PRIO_W-VALUE_W){val[VALUE_W-1]}}, val});
    return id_x + val_x;
  endfunction

endpackage

>>> src/spil_ctrl.sv
// Controller state machine for the sorted priority insert list.
// Drives input ready, output valid and the datapath commands.
// Depends on spil_pkg.
`timescale 1ns / 1ps

module spil_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  input  spil_pkg::spil_stat_t stat,
  output spil_pkg::spil_cmd_t  cmd
);
  import spil_pkg::*;

  spil_state_t state, state_next;
  logic        rsp_valid_next;
  logic        out_free;

  assign out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = stat.req_list ? ST_LIST : ST_INS;
        end
      end
      ST_INS: begin
        if (out_free) begin
          cmd.emit_ins = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_LIST: begin
        if (out_free) begin
          cmd.emit_list = 1'b1;
          if (stat.list_done) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    rsp_valid_next = (cmd.emit_ins || cmd.emit_list) ? 1'b1
                   : (rsp_ready ? 1'b0 : rsp_valid);
  end

`ifndef SYNTH
  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit_ins && cmd.emit_list))
    else $error("insert and listing emitted in the same cycle");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_ins || cmd.emit_list) |-> (!rsp_valid || rsp_ready))
    else $error("output register overwritten while held");

  a_capture_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state != ST_IDLE && !req_ready))
    else $error("accepted a transaction while one is in progress");
`endif

endmodule

>>> src/spil_dp.sv
// Datapath for the sorted priority insert list: the sorted row of cells,
// parallel priority compare, insert shift, listing rotate and output register.
// Depends on spil_pkg.
`timescale 1ns / 1ps

module spil_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  spil_pkg::spil_req_t  req_item,
  output spil_pkg::spil_rsp_t  rsp_item,
  input  spil_pkg::spil_cmd_t  cmd,
  output spil_pkg::spil_stat_t stat
);
  import spil_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [ID_W-1:0]           cell_id  [CAPACITY];
  logic signed [VALUE_W-1:0] cell_val [CAPACITY];

  spil_req_t                 item;
  logic [CAPACITY-1:0]       gt;
  logic [CAPACITY-1:0]       gt_new;
  logic [CAPACITY-1:0]       first_gt;
  logic [CW-1:0]             count;
  logic [CW-1:0]             cnt_m1;
  logic [IW-1:0]             list_idx;
  logic [IW-1:0]             pos;
  logic                      full;
  logic                      empty;
  logic signed [PRIO_W-1:0]  new_prio;

  assign full     = (count == CW'(CAPACITY));
  assign empty    = (count == '0);
  assign cnt_m1   = count - CW'(1);
  assign new_prio = prio_f(req_item.new_id, req_item.new_value);

  assign stat.req_list  = (req_item.command == CMD_LIST);
  assign stat.list_done = empty || (CW'(list_idx) == cnt_m1);

  // Stored order is ascending, so the compare vector is a thermometer.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt_new[i] = (CW'(i) < count) && (prio_f(cell_id[i], cell_val[i]) > new_prio);
    end
  end

  // Insert slot: first cell with greater priority, else the tail.
  assign first_gt = gt & ~(gt << 1);
  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_gt[i]) begin
        pos = pos | IW'(i);
      end
    end
    if (gt == '0) begin
      pos = count[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.emit_ins && !full) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item     <= req_item;
      gt       <= gt_new;
      list_idx <= '0;
    end
    if (cmd.emit_ins) begin
      if (!full) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (pos == IW'(i)) begin
            cell_id[i]  <= item.new_id;
            cell_val[i] <= item.new_value;
          end else if (i > 0 && gt[(i + CAPACITY - 1) % CAPACITY]) begin
            cell_id[i]  <= cell_id[(i + CAPACITY - 1) % CAPACITY];
            cell_val[i] <= cell_val[(i + CAPACITY - 1) % CAPACITY];
          end
        end
      end
      rsp_item.entry_id    <= item.new_id;
      rsp_item.entry_value <= item.new_value;
      rsp_item.rank        <= full ? '0 : RANK_W'(pos);
      rsp_item.is_listing  <= 1'b0;
      rsp_item.empty_res   <= 1'b0;
      rsp_item.rejected    <= full;
      rsp_item.last        <= 1'b1;
    end
    if (cmd.emit_list) begin
      if (empty) begin
        rsp_item.entry_id    <= '0;
        rsp_item.entry_value <= '0;
        rsp_item.rank        <= '0;
        rsp_item.empty_res   <= 1'b1;
      end else begin
        rsp_item.entry_id    <= cell_id[0];
        rsp_item.entry_value <= cell_val[0];
        rsp_item.rank        <= RANK_W'(list_idx);
        rsp_item.empty_res   <= 1'b0;
        // rotate the occupied cells so the next entry reaches cell 0
        for (int i = 0; i < CAPACITY; i++) begin
          if (CW'(i) == cnt_m1) begin
            cell_id[i]  <= cell_id[0];
            cell_val[i] <= cell_val[0];
          end else if (CW'(i) < cnt_m1) begin
            cell_id[i]  <= cell_id[(i + 1) % CAPACITY];
            cell_val[i] <= cell_val[(i + 1) % CAPACITY];
          end
        end
        list_idx <= list_idx + IW'(1);
      end
      rsp_item.is_listing <= 1'b1;
      rsp_item.rejected   <= 1'b0;
      rsp_item.last       <= stat.list_done;
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_ins && !full) |=> (count == $past(count) + CW'(1)))
    else $error("insert did not grow the list by one");

  a_list_idx: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_list && !empty) |-> (CW'(list_idx) <= cnt_m1))
    else $error("listing ran past the stored entries");
`endif

endmodule

>>> src/sorted_priority_insert_list.sv
// Sorted priority insert list: top level.
// Instantiates the controller (spil_ctrl) and the datapath (spil_dp).
// Depends on spil_pkg.
//
// Usage:
//   req channel (req_valid/req_ready/req_item) takes one transaction at a time:
//   command insert adds {new_id, new_value} keyed by priority new_id + new_value;
//   command list streams every stored entry in ascending priority order.
//   rsp channel (rsp_valid/rsp_ready/rsp_item) returns results from an output
//   register, so the next request is taken while a result waits there.
// Sequence and throughput:
//   insert: one result; the request is captured with its compare result, then the
//   cells shift and the result is loaded before a new request is taken.
//   list: n results (one when empty), one per cycle from the output register while
//   ready is held high (the cell rotation sets this rate); then a new request is taken.
// Reset (rst, synchronous): empties the list and clears output valid. Cell
//   contents are not cleared; only occupied cells are ever read.
// Receiver stall: the output register holds its result, the controller waits
//   in its current step, and no further request is taken until it moves on.
`timescale 1ns / 1ps

module sorted_priority_insert_list #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  spil_pkg::spil_req_t req_item,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output spil_pkg::spil_rsp_t rsp_item
);
  import spil_pkg::*;

  // command and status between controller and datapath
  spil_cmd_t  cmd;
  spil_stat_t stat;

  // sequence transactions: accept, insert or list, emit results
  spil_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // hold the sorted cells and the output register
  spil_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req_item (req_item),
    .rsp_item (rsp_item),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

>>> tb/tb.sv
// Testbench for sorted_priority_insert_list. Directed and random inserts and listings
// are checked field by field against a sorted-list predictor kept in the bench.
// Depends on spil_pkg and the sorted_priority_insert_list RTL.
`timescale 1ns / 1ps

module tb;
  import spil_pkg::*;

  localparam int DEPTH        = 64;
  localparam int RANDOM_ITEMS = 360;
  localparam int LONG_HOLD    = 300;   // receiver hold-off, in cycles
  localparam int MAX_REPORTS  = 50;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  spil_req_t req_item  = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  spil_rsp_t rsp_item;

  sorted_priority_insert_list #(.CAPACITY(DEPTH)) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_item  (rsp_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted list contents, kept in ascending priority order.
  logic [ID_W-1:0]           sorted_ids [DEPTH];
  logic signed [VALUE_W-1:0] sorted_vals[DEPTH];
  int                        sorted_len = 0;

  spil_req_t req_backlog[$];   // transactions not yet offered to the block
  spil_rsp_t due_results[$];   // results the block still owes, oldest first

  int n_placed   = 0;
  int n_refused  = 0;
  int n_listings = 0;
  int n_checked  = 0;
  int n_errors   = 0;

  // Apply one accepted transaction to the predicted list and queue the
  // results it must produce.
  function automatic void apply_request(input spil_req_t req);
    spil_rsp_t r;
    int        prio;
    int        pos;
    int        i;
    r = '0;
    if (req.command == CMD_LIST) begin
      n_listings++;
      r.is_listing = 1'b1;
      if (sorted_len == 0) begin
        // empty list: a single flagged result with zero payload
        r.empty_res = 1'b1;
        r.last      = 1'b1;
        due_results.push_back(r);
      end else begin
        for (i = 0; i < sorted_len; i++) begin
          r.entry_id    = sorted_ids[i];
          r.entry_value = sorted_vals[i];
          r.rank        = RANK_W'(i);
          r.last        = (i == sorted_len - 1);
          due_results.push_back(r);
        end
      end
    end else begin
      r.entry_id    = req.new_id;
      r.entry_value = req.new_value;
      r.last        = 1'b1;
      if (sorted_len >= DEPTH) begin
        // full: list untouched, echo the offer with rank 0
        r.rejected = 1'b1;
        n_refused++;
      end else begin
        prio = int'(req.new_id) + int'($signed(req.new_value));
        // Walk back from the tail past every strictly greater priority,
        // so equal priorities stay in arrival order.
        pos = sorted_len;
        while (pos > 0 && int'(sorted_ids[pos-1]) + int'(sorted_vals[pos-1]) > prio) begin
          sorted_ids[pos]  = sorted_ids[pos-1];
          sorted_vals[pos] = sorted_vals[pos-1];
          pos--;
        end
        sorted_ids[pos]  = req.new_id;
        sorted_vals[pos] = req.new_value;
        sorted_len++;
        r.rank = RANK_W'(pos);
        n_placed++;
      end
      due_results.push_back(r);
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      if (n_errors < MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      n_errors++;
    end
  endfunction

  function automatic void queue_insert(input int id, input int val);
    spil_req_t q;
    q.command   = CMD_INSERT;
    q.new_id    = ID_W'(id);
    q.new_value = VALUE_W'(val);
    req_backlog.push_back(q);
  endfunction

  function automatic void queue_listing();
    spil_req_t q;
    q.command   = CMD_LIST;
    q.new_id    = ID_W'($urandom);      // ignored by the block, so carry noise
    q.new_value = VALUE_W'($urandom);
    req_backlog.push_back(q);
  endfunction

  function automatic void queue_random_insert();
    int id;
    int val;
    int kind;
    kind = $urandom_range(0, 9);
    id   = $urandom_range(0, 255);
    if (kind < 4)
      // land on a handful of priorities so ties with stored entries are common
      val = int'($urandom_range(0, 6)) * 50 - 150 - id;
    else if (kind == 4)
      val = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
    else
      val = int'($signed(VALUE_W'($urandom)));
    queue_insert(id, val);
  endfunction

  // Driver: offer the backlog one transaction at a time. Hold valid and
  // payload until accepted, then draw a random idle gap. Every third
  // block of 50 transactions runs with no gaps at all.
  int gap_left   = 0;
  int n_accepted = 0;

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        apply_request(req_item);
        n_accepted++;
        gap_left = ((n_accepted / 50) % 3 == 2) ? 0 : $urandom_range(0, 4);
      end
      if (!req_valid || req_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          req_item  <= req_backlog.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest expectation, then draw a
  // random stall. Some stretches run with ready held high; twice in the
  // run ready drops for a long stretch so the block backs up into its input.
  spil_rsp_t want;
  int        rsp_wait  = 0;
  int        hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (due_results.size() == 0) begin
          if (n_errors < MAX_REPORTS)
            $display("%0t ns: unexpected result, id %0d value %0d rank %0d listing %0b",
                     $time, rsp_item.entry_id, rsp_item.entry_value, rsp_item.rank,
                     rsp_item.is_listing);
          n_errors++;
        end else begin
          want = due_results.pop_front();
          check_field("entry_id", want.entry_id, rsp_item.entry_id);
          check_field("entry_value", $signed(want.entry_value), $signed(rsp_item.entry_value));
          check_field("rank", want.rank, rsp_item.rank);
          check_field("is_listing", want.is_listing, rsp_item.is_listing);
          check_field("empty_res", want.empty_res, rsp_item.empty_res);
          check_field("rejected", want.rejected, rsp_item.rejected);
          check_field("last", want.last, rsp_item.last);
        end
        n_checked++;
        rsp_wait = ((n_checked / 200) % 3 == 1) ? 0 : $urandom_range(0, 4);
        if (n_checked == 40 || n_checked == 1500)
          hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (rsp_wait > 0) begin
        rsp_wait--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  initial begin
    int k;
    // Directed: empty listing, field extremes, ties, repeated ids.
    queue_listing();
    queue_insert(0, -32768);
    queue_insert(255, 32767);
    queue_insert(0, 0);
    queue_insert(255, -32768);
    queue_insert(10, 5);       // these four share priority 15
    queue_insert(5, 10);
    queue_insert(15, 0);
    queue_insert(200, -185);
    queue_insert(15, 0);       // same id again is a separate entry
    queue_insert(255, -255);   // ties with the zero-priority entry
    queue_insert(128, 127);
    queue_listing();
    queue_insert(1, -1);
    queue_listing();

    // Random: mostly inserts, about one listing in five. The list fills
    // early, after which inserts are turned away and listings run full.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if ($urandom_range(0, 4) == 0)
        queue_listing();
      else
        queue_random_insert();
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (req_backlog.size() > 0 || req_valid || due_results.size() > 0)
      @(posedge clk);
    // give a stray result time to show up after the last expected one
    repeat (80) @(posedge clk);

    $display("Run covered %0d inserts placed, %0d turned away on a full list, %0d listings.",
             n_placed, n_refused, n_listings);
    $display("%0d results checked, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results still owed.", due_results.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> files.f
src/spil_pkg.sv
src/spil_ctrl.sv
src/spil_dp.sv
src/sorted_priority_insert_list.sv
tb/tb.sv
